>>> src/oal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_pkg: shared types for the ordered array list
// operation codes, status codes and the command and result records
// that pass between the top level and the move sequencer
// ----------------------------------------------------------------------------
package oal_pkg;

   // widest count and payload over the whole parameter range
   localparam int CNT_W     = 9;
   localparam int PAY_W     = 56;
   localparam int KEY_W     = 8;
   localparam int IDX_W     = 5;
   localparam int FIELD_W   = 5;
   localparam int IN_PAY_W  = 48;
   localparam int MODE_W    = 3;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   typedef logic [CNT_W-1:0] wcnt_type;
   typedef logic [PAY_W-1:0] wpay_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_BACK  = 3'd1,
      MODE_INS_AT    = 3'd2,
      MODE_DEL_FRONT = 3'd3,
      MODE_DEL_BACK  = 3'd4,
      MODE_DEL_KEY   = 3'd5,
      MODE_READ      = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // work handed to the sequencer
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_UP    = 2'd1,
      OP_DOWN  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      op_type           op;
      status_type       status;
      wcnt_type         pos;
      wcnt_type         count;
      logic             rm_one;
      logic [KEY_W-1:0] key;
      wpay_type         payload;
      logic [KEY_W-1:0] mkey;
      logic             drop_front;
      logic             drop_key;
   } cmd_type;

   typedef struct packed {
      status_type       status;
      wcnt_type         count;
      wcnt_type         removed;
      logic [KEY_W-1:0] rkey;
      wpay_type         rpay;
   } res_type;

endpackage

>>> src/ordered_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list: bounded ordered list of key and payload records
// insert, delete, compact-by-key and read on a list packed from position 0
// ----------------------------------------------------------------------------
// The list holds up to CAPACITY records (8-bit key plus PAYLOAD_WIDTH-bit
// payload) in one ram with a single write port and a registered read port,
// packed from position 0. Each request item carries an operation in req_tuser
// and yields exactly one response item. Records are moved one per cycle by a
// small sequencer that reads a position and writes it back in the next cycle,
// so the cost of an item is set by how many records it has to move: an insert
// at position p shifts each record at or above p up by one, an append moves
// none, delete-front and delete-by-key walk every entry, a read fetches one
// position, and delete-back, refused items and the unused mode move nothing.
// While an item is in work req_tready is low; the response is held in an
// output register, and a new request is taken while the previous response
// still waits. The ram needs no clearing after reset, since only positions
// below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_array_list #(
   parameter int CAPACITY      = 16,
   parameter int PAYLOAD_WIDTH = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // index[4:0], elem_key[12:5], elem_payload[60:13], match_key[68:61], zero
   input  logic [oal_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[2:0]
   input  logic [oal_pkg::MODE_W-1:0]        req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[1:0], count_after[6:2], removed[11:7], read_key[19:12],
   // read_payload[67:20], zero
   output logic [oal_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = PAYLOAD_WIDTH + 8;

   // request fields
   logic [oal_pkg::IDX_W-1:0]    req_index;
   logic [7:0]                   req_key;
   logic [oal_pkg::IN_PAY_W-1:0] req_payload;
   logic [7:0]                   req_mkey;
   oal_pkg::mode_type            req_mode;

   assign req_index   = req_tdata[4:0];
   assign req_key     = req_tdata[12:5];
   assign req_payload = req_tdata[60:13];
   assign req_mkey    = req_tdata[68:61];
   assign req_mode    = oal_pkg::mode_type'(req_tuser);

   // control state
   logic                  busy_ff, busy_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [oal_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  take;
   logic                  done;
   oal_pkg::cmd_type      cmd;
   oal_pkg::res_type      res;

   // ram ports
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [DW-1:0]         ram_wdata;
   logic                  ram_re;
   logic [AW-1:0]         ram_raddr;
   logic [DW-1:0]         ram_rdata;

   // one item in work at a time
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   // result moves to the output register once it is free
   assign take       = done && (!rsp_valid_ff || rsp_tready);

   // decode the item against the current count
   logic                  full;
   logic                  empty;
   oal_pkg::wcnt_type     count_w;
   oal_pkg::wcnt_type     index_w;

   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign count_w = oal_pkg::wcnt_type'(count_ff);
   assign index_w = oal_pkg::wcnt_type'(req_index);

   always_comb begin
      cmd            = '0;
      cmd.op         = oal_pkg::OP_NONE;
      cmd.status     = oal_pkg::ST_OK;
      cmd.count      = count_w;
      cmd.key        = req_key;
      cmd.payload    = oal_pkg::wpay_type'(req_payload);
      cmd.mkey       = req_mkey;
      unique case (req_mode)
         oal_pkg::MODE_INS_FRONT, oal_pkg::MODE_INS_BACK, oal_pkg::MODE_INS_AT: begin
            // full takes precedence over a bad index
            if (full) begin
               cmd.status = oal_pkg::ST_FULL;
            end else if (req_mode == oal_pkg::MODE_INS_FRONT) begin
               cmd.op  = oal_pkg::OP_UP;
               cmd.pos = '0;
            end else if (req_mode == oal_pkg::MODE_INS_BACK) begin
               cmd.op  = oal_pkg::OP_UP;
               cmd.pos = count_w;
            end else if (index_w > count_w) begin
               cmd.status = oal_pkg::ST_RANGE;
            end else begin
               cmd.op  = oal_pkg::OP_UP;
               cmd.pos = index_w;
            end
         end
         oal_pkg::MODE_DEL_FRONT: begin
            if (empty) begin
               cmd.status = oal_pkg::ST_EMPTY;
            end else begin
               cmd.op         = oal_pkg::OP_DOWN;
               cmd.drop_front = 1'b1;
            end
         end
         oal_pkg::MODE_DEL_BACK: begin
            // last entry just falls off the end
            if (empty) begin
               cmd.status = oal_pkg::ST_EMPTY;
            end else begin
               cmd.count  = oal_pkg::wcnt_type'(count_ff - CW'(1));
               cmd.rm_one = 1'b1;
            end
         end
         oal_pkg::MODE_DEL_KEY: begin
            if (empty) begin
               cmd.status = oal_pkg::ST_EMPTY;
            end else begin
               cmd.op       = oal_pkg::OP_DOWN;
               cmd.drop_key = 1'b1;
            end
         end
         oal_pkg::MODE_READ: begin
            if (index_w >= count_w) begin
               cmd.status = oal_pkg::ST_RANGE;
            end else begin
               cmd.op  = oal_pkg::OP_READ;
               cmd.pos = index_w;
            end
         end
         default: cmd.op = oal_pkg::OP_NONE;
      endcase
   end

   oal_walk #(
      .CAPACITY      (CAPACITY),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .cmd       (cmd),
      .take      (take),
      .done      (done),
      .res       (res),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   oal_ram #(
      .WIDTH (DW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // handshake and count bookkeeping
   always_comb begin
      busy_in      = busy_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      if (take) begin
         busy_in      = 1'b0;
         count_in     = res.count[CW-1:0];
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000,
                         res.rpay[oal_pkg::IN_PAY_W-1:0],
                         res.rkey,
                         res.removed[oal_pkg::FIELD_W-1:0],
                         res.count[oal_pkg::FIELD_W-1:0],
                         res.status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // the list never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // a refused item leaves the count alone
   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (take && (res.status != oal_pkg::ST_OK)) |=> (count_ff == $past(count_ff)))
      else $error("refused item changed the count");

   // a delete never removes more than the list held
   a_removed_bound: assert property (@(posedge clock) disable iff (reset)
      take |-> (res.removed <= count_w))
      else $error("removed more entries than present");

   // entries removed and entries left add up to the count before
   a_removed_balance: assert property (@(posedge clock) disable iff (reset)
      (take && (res.removed != '0)) |->
         (res.count + res.removed == count_w))
      else $error("removed and remaining entries do not balance");

   // the sequencer only finishes an item that was accepted
   a_done_needs_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("result without an item in work");
`endif

endmodule

>>> src/oal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_ram: generic single-write single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module oal_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/oal_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_walk: move sequencer of the ordered array list
// walks the entry ram one position a cycle to shift up, compact or read
// ----------------------------------------------------------------------------
module oal_walk #(
   parameter int CAPACITY      = 16,
   parameter int PAYLOAD_WIDTH = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  oal_pkg::cmd_type            cmd,
   input  logic                        take,
   output logic                        done,
   output oal_pkg::res_type            res,
   output logic                        ram_we,
   output logic [$clog2(CAPACITY)-1:0] ram_waddr,
   output logic [PAYLOAD_WIDTH+7:0]    ram_wdata,
   output logic                        ram_re,
   output logic [$clog2(CAPACITY)-1:0] ram_raddr,
   input  logic [PAYLOAD_WIDTH+7:0]    ram_rdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = PAYLOAD_WIDTH + 8;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_UP    = 8'b0000_0010,
      S_UPW   = 8'b0000_0100,
      S_PUT   = 8'b0000_1000,
      S_DOWN  = 8'b0001_0000,
      S_DRAIN = 8'b0010_0000,
      S_READ  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   oal_pkg::cmd_type cmd_ff, cmd_in;
   logic [CW-1:0]    src_ff, src_in;
   logic [CW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]    rm_ff, rm_in;
   logic             mv_valid_ff, mv_valid_in;
   logic [CW-1:0]    mv_addr_ff, mv_addr_in;

   logic [CW-1:0]    cnt;
   logic [CW-1:0]    pos;
   logic [7:0]       rd_key;
   logic             drop;

   assign cnt    = cmd_ff.count[CW-1:0];
   assign pos    = cmd_ff.pos[CW-1:0];
   assign rd_key = ram_rdata[DW-1 -: 8];
   assign drop   = (cmd_ff.drop_front && (mv_addr_ff == '0)) ||
                   (cmd_ff.drop_key && (rd_key == cmd_ff.mkey));

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      src_in      = src_ff;
      mv_valid_in = 1'b0;
      mv_addr_in  = mv_addr_ff;
      ram_re      = 1'b0;
      ram_raddr   = src_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = cmd;
               unique case (cmd.op)
                  oal_pkg::OP_UP: begin
                     src_in   = CW'(cmd.count[CW-1:0] - CW'(1));
                     state_in = (cmd.pos[CW-1:0] == cmd.count[CW-1:0]) ? S_PUT : S_UP;
                  end
                  oal_pkg::OP_DOWN: begin
                     src_in   = '0;
                     state_in = S_DOWN;
                  end
                  oal_pkg::OP_READ: state_in = S_READ;
                  default:          state_in = S_DONE;
               endcase
            end
         end
         S_UP: begin
            ram_re      = 1'b1;
            mv_valid_in = 1'b1;
            mv_addr_in  = CW'(src_ff + CW'(1));
            if (src_ff == pos) begin
               state_in = S_UPW;
            end else begin
               src_in = CW'(src_ff - CW'(1));
            end
         end
         S_UPW:  state_in = S_PUT;
         S_PUT:  state_in = S_DONE;
         S_DOWN: begin
            ram_re      = 1'b1;
            mv_valid_in = 1'b1;
            mv_addr_in  = src_ff;
            if (src_ff == CW'(cnt - CW'(1))) begin
               state_in = S_DRAIN;
            end else begin
               src_in = CW'(src_ff + CW'(1));
            end
         end
         S_DRAIN: state_in = S_DONE;
         S_READ: begin
            ram_re    = 1'b1;
            ram_raddr = pos[AW-1:0];
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // shared move unit: write back what was read in the previous cycle
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = mv_addr_ff[AW-1:0];
      ram_wdata = ram_rdata;
      wr_ptr_in = wr_ptr_ff;
      rm_in     = rm_ff;
      if (state_ff == S_IDLE) begin
         wr_ptr_in = '0;
         rm_in     = '0;
      end
      if (mv_valid_ff) begin
         if (cmd_ff.op == oal_pkg::OP_UP) begin
            ram_we = 1'b1;
         end else if (drop) begin
            rm_in = CW'(rm_ff + CW'(1));
         end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_ff[AW-1:0];
            wr_ptr_in = CW'(wr_ptr_ff + CW'(1));
         end
      end
      if (state_ff == S_PUT) begin
         ram_we    = 1'b1;
         ram_waddr = pos[AW-1:0];
         ram_wdata = {cmd_ff.key, cmd_ff.payload[PAYLOAD_WIDTH-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         mv_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mv_valid_ff <= mv_valid_in;
      end
      cmd_ff     <= cmd_in;
      src_ff     <= src_in;
      wr_ptr_ff  <= wr_ptr_in;
      rm_ff      <= rm_in;
      mv_addr_ff <= mv_addr_in;
   end

   // result record
   always_comb begin
      res.status  = cmd_ff.status;
      res.count   = oal_pkg::wcnt_type'(cnt);
      res.removed = oal_pkg::wcnt_type'(cmd_ff.rm_one);
      res.rkey    = '0;
      res.rpay    = '0;
      unique case (cmd_ff.op)
         oal_pkg::OP_UP: res.count = oal_pkg::wcnt_type'(cnt) + oal_pkg::wcnt_type'(1);
         oal_pkg::OP_DOWN: begin
            res.count   = oal_pkg::wcnt_type'(wr_ptr_ff);
            res.removed = oal_pkg::wcnt_type'(rm_ff);
         end
         oal_pkg::OP_READ: begin
            res.rkey = rd_key;
            res.rpay = oal_pkg::wpay_type'(ram_rdata[PAYLOAD_WIDTH-1:0]);
         end
         default: res.count = oal_pkg::wcnt_type'(cnt);
      endcase
   end

   assign done = (state_ff == S_DONE);

endmodule
